@@ hdl/qsm_pkg.sv @@
package qsm_pkg;

	// register map indexes (byte address = 4 * index)
	localparam logic [1:0] REG_CPR    = 2'd0;
	localparam logic [1:0] REG_PERIOD = 2'd1;
	localparam logic [1:0] REG_INVERT = 2'd2;

	// register reset values
	localparam logic [31:0] RST_CPR    = 32'd256;
	localparam logic [15:0] RST_PERIOD = 16'd10;

	// fixed-point constants
	localparam int          RPM_W       = 16;
	localparam logic [15:0] RPM_FACTOR  = 16'd60000;
	localparam int          KW          = 29;
	localparam logic [28:0] RADS_K      = 29'd449768975;
	localparam int          FRAC_SHIFT  = 24;
	localparam int          D_W         = 48;

	// Gray decode direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DN   = 2'd2;

	typedef struct packed {
		logic [31:0] counts_per_rev;
		logic [15:0] period_ms;
		logic        invert;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic sample;
		logic tick;
		logic mul;
		logic klo;
		logic khi;
		logic dload;
		logic dstep;
		logic oload;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rads;
		logic skip;
		logic div_last;
		logic out_free;
	} stat_t;

	// one-step Gray code direction: 00->01->11->10->00 counts up
	function automatic logic [1:0] gray_dir(input logic [1:0] prev_ab, input logic [1:0] ab);
		logic [1:0] dir;
		dir = DIR_NONE;
		case (prev_ab)
			2'b00: dir = (ab == 2'b01) ? DIR_UP : (ab == 2'b10) ? DIR_DN : DIR_NONE;
			2'b01: dir = (ab == 2'b11) ? DIR_UP : (ab == 2'b00) ? DIR_DN : DIR_NONE;
			2'b10: dir = (ab == 2'b00) ? DIR_UP : (ab == 2'b11) ? DIR_DN : DIR_NONE;
			default: dir = (ab == 2'b10) ? DIR_UP : (ab == 2'b01) ? DIR_DN : DIR_NONE;
		endcase
		return dir;
	endfunction

endpackage

@@ hdl/qsm_item_if.sv @@
interface qsm_item_if;
	logic valid;
	logic ready;
	logic req_type;
	logic enc_a;
	logic enc_b;
	logic speed_unit;

	modport source (output valid, output req_type, output enc_a, output enc_b,
		output speed_unit, input ready);
	modport sink (input valid, input req_type, input enc_a, input enc_b,
		input speed_unit, output ready);
endinterface

@@ hdl/qsm_result_if.sv @@
interface qsm_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] speed_value;
	logic        speed_saturated;

	modport source (output valid, output speed_value, output speed_saturated, input ready);
	modport sink (input valid, input speed_value, input speed_saturated, output ready);
endinterface

@@ hdl/qsm_regs.sv @@
module qsm_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output qsm_pkg::cfg_t     cfg
);

	logic              wr_en;
	logic [1:0]        idx;
	qsm_pkg::cfg_t     cfg_q;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counts_per_rev <= qsm_pkg::RST_CPR;
			cfg_q.period_ms      <= qsm_pkg::RST_PERIOD;
			cfg_q.invert         <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				qsm_pkg::REG_CPR:    cfg_q.counts_per_rev <= pwdata;
				qsm_pkg::REG_PERIOD: cfg_q.period_ms      <= pwdata[15:0];
				qsm_pkg::REG_INVERT: cfg_q.invert         <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			qsm_pkg::REG_CPR:    prdata = cfg_q.counts_per_rev;
			qsm_pkg::REG_PERIOD: prdata = {16'b0, cfg_q.period_ms};
			qsm_pkg::REG_INVERT: prdata = {31'b0, cfg_q.invert};
			default:             prdata = 32'b0;
		endcase
	end

endmodule

@@ hdl/qsm_ctrl.sv @@
module qsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_req_type,
	input  qsm_pkg::stat_t  st,
	output logic            in_ready,
	output qsm_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_KLO  = 3'd2;
	localparam logic [2:0] S_KHI  = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// take samples; run ticks: multiply, divide, output load
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_req_type) begin
						cmd.tick = 1'b1;
						state_nx = S_MUL;
					end else begin
						cmd.sample = 1'b1;
					end
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = st.rads ? S_KLO : S_LOAD;
			end
			S_KLO: begin
				cmd.klo  = 1'b1;
				state_nx = S_KHI;
			end
			S_KHI: begin
				cmd.khi  = 1'b1;
				state_nx = S_LOAD;
			end
			S_LOAD: begin
				if (st.skip) begin
					state_nx = S_FIN;
				end else begin
					cmd.dload = 1'b1;
					state_nx  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.dstep = 1'b1;
				if (st.div_last) state_nx = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.oload = 1'b1;
					state_nx  = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nx;
	end

	// at most one datapath action per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sample, cmd.tick, cmd.mul, cmd.klo, cmd.khi, cmd.dload, cmd.dstep,
			cmd.oload}))
		else $error("qsm_ctrl: overlapping datapath commands");

	// a skipped division never loads the divider
	a_no_step_on_skip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dload |-> !st.skip)
		else $error("qsm_ctrl: divider loaded for a zero case");

	// the item side stays closed while a tick is in progress
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("qsm_ctrl: item taken during a tick");

endmodule

@@ hdl/qsm_dp.sv @@
module qsm_dp #(
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qsm_pkg::cfg_t        cfg,
	input  qsm_pkg::cmd_t        cmd,
	input  logic                 enc_a,
	input  logic                 enc_b,
	input  logic                 speed_unit,
	output qsm_pkg::stat_t       st,
	qsm_result_if.source         result
);

	localparam int NW    = COUNT_BITS + qsm_pkg::RPM_W - 1;
	localparam int HALF  = (NW + 1) / 2;
	localparam int HI_W  = NW - HALF;
	localparam int P_W   = NW + qsm_pkg::KW;
	localparam int NUM_W = P_W + qsm_pkg::FRAC_SHIFT;
	localparam int CW    = $clog2(NUM_W);
	localparam int D_W   = qsm_pkg::D_W;
	localparam logic [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

	// decoder state
	logic [1:0]            prev_ab_q;
	logic                  primed_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  cclip_q;
	logic [1:0]            ab;
	logic [1:0]            dir;

	// tick operands
	logic [COUNT_BITS-1:0] mag_q;
	logic                  neg_q;
	logic                  rads_q;
	logic                  mag_zero_q;
	logic                  tclip_q;
	logic [COUNT_BITS-1:0] mag_c;

	// multiply and divide
	logic [COUNT_BITS+qsm_pkg::RPM_W-1:0] n_full;
	logic [NW-1:0]          n_q;
	logic [D_W-1:0]         d_q;
	logic [P_W-1:0]         prod_q;
	logic [HALF+qsm_pkg::KW-1:0] plo;
	logic [HI_W+qsm_pkg::KW-1:0] phi;
	logic [NUM_W-1:0]       num_q;
	logic [D_W-1:0]         rem_q;
	logic [CW-1:0]          cnt_q;
	logic [D_W:0]           rem_sh;
	logic [D_W:0]           diff;
	logic                   qbit;

	// finish
	logic                   over;
	logic [31:0]            val;
	logic [31:0]            limit;
	logic [31:0]            qv;
	logic                   clip;
	logic [31:0]            res;

	// output register
	logic                   ovalid_q;
	logic [31:0]            oval_q;
	logic                   osat_q;

	assign ab  = {enc_a, enc_b};
	assign dir = qsm_pkg::gray_dir(prev_ab_q, ab);
	assign mag_c = count_q[COUNT_BITS-1] ? (~count_q + 1'b1) : count_q;

	// track pins and the saturating edge count; clear on tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= 2'b00;
			primed_q  <= 1'b0;
			count_q   <= '0;
			cclip_q   <= 1'b0;
		end else if (cmd.sample) begin
			prev_ab_q <= ab;
			primed_q  <= 1'b1;
			if (primed_q) begin
				if (dir == qsm_pkg::DIR_UP) begin
					if (count_q == CMAX) cclip_q <= 1'b1;
					else                 count_q <= count_q + 1'b1;
				end else if (dir == qsm_pkg::DIR_DN) begin
					if (count_q == CMIN) cclip_q <= 1'b1;
					else                 count_q <= count_q - 1'b1;
				end
			end
		end else if (cmd.tick) begin
			count_q <= '0;
			cclip_q <= 1'b0;
		end
	end

	// latch tick operands
	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			mag_q      <= mag_c;
			neg_q      <= count_q[COUNT_BITS-1] ^ cfg.invert;
			rads_q     <= speed_unit;
			mag_zero_q <= (count_q == '0);
			tclip_q    <= cclip_q;
		end
	end

	assign n_full = mag_q * qsm_pkg::RPM_FACTOR;
	assign plo    = n_q[HALF-1:0] * qsm_pkg::RADS_K;
	assign phi    = n_q[NW-1:HALF] * qsm_pkg::RADS_K;

	// scale numerator, form divisor, apply rad/s factor in two halves
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			n_q <= n_full[NW-1:0];
			d_q <= {16'b0, cfg.counts_per_rev} * {32'b0, cfg.period_ms};
		end
		if (cmd.klo) prod_q <= {{HI_W{1'b0}}, plo};
		if (cmd.khi) prod_q <= prod_q + {phi, {HALF{1'b0}}};
	end

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, d_q};
	assign qbit   = !diff[D_W];

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.dload) begin
			num_q <= rads_q ? {prod_q, {qsm_pkg::FRAC_SHIFT{1'b0}}}
				: {{qsm_pkg::KW{1'b0}}, n_q, {qsm_pkg::FRAC_SHIFT{1'b0}}};
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.dstep) begin
			rem_q <= qbit ? diff[D_W-1:0] : rem_sh[D_W-1:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// select quotient window, clip and sign
	always_comb begin
		if (rads_q) begin
			over = |num_q[NUM_W-1:64];
			val  = num_q[63:32];
		end else begin
			over = |num_q[NUM_W-1:32];
			val  = num_q[31:0];
		end
		limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		if (mag_zero_q) begin
			clip = 1'b0;
			qv   = 32'b0;
		end else if (d_q == '0) begin
			clip = 1'b1;
			qv   = limit;
		end else begin
			clip = over || (val > limit);
			qv   = clip ? limit : val;
		end
		res = neg_q ? (~qv + 32'd1) : qv;
	end

	// output register: load a beat, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.oload) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.oload) begin
			oval_q <= res;
			osat_q <= clip || tclip_q;
		end
	end

	assign result.valid           = ovalid_q;
	assign result.speed_value     = oval_q;
	assign result.speed_saturated = osat_q;

	assign st.rads     = rads_q;
	assign st.skip     = mag_zero_q || (d_q == '0);
	assign st.div_last = (cnt_q == CW'(NUM_W - 1));
	assign st.out_free = !ovalid_q || result.ready;

	// the count only moves on a sample or a tick
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sample || cmd.tick) |=> $stable(count_q))
		else $error("qsm_dp: edge count changed without a sample or tick");

	// a tick leaves a cleared count and clip flag
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> (count_q == '0) && !cclip_q)
		else $error("qsm_dp: tick did not clear the count");

	// a new beat never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.oload |-> (!ovalid_q || result.ready))
		else $error("qsm_dp: output beat overwritten");

endmodule

@@ hdl/quadrature_speed_meter.sv @@
// Quadrature encoder decoder with speed measurement.
// item channel: one beat is either a pin sample (req_type 0, enc_a/enc_b)
// or a period tick (req_type 1, speed_unit 0 RPM / 1 rad/s).
// result channel: one beat per tick with a Q8.24 signed speed and a
// saturation flag; samples give no result.
// A sample is taken while the block is idle, so samples can stream every
// clock while no tick is in progress. A tick runs multiply, two scaling
// steps in rad/s only, divider load, division and finish. The quotient
// is NUM_W = COUNT_BITS + 68 bits wide (100 at the default) and comes from
// the restoring divider, which retires one quotient bit a cycle.
// Ticks whose count or divisor is zero skip the divider.
// item.ready is low while a tick is in progress.
// The result sits in an output register; the block keeps taking items while
// it waits, and a following tick holds in its last step until the receiver
// takes the earlier beat.
// Reset clears the count, the primed flag and the output valid, and loads
// counts_per_rev = 256, period_ms = 10, invert = 0. Registers sit on an
// APB port at byte addresses 0, 4 and 8; pready is always high.
module quadrature_speed_meter #(
	parameter int COUNT_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	qsm_item_if.sink     item,
	qsm_result_if.source result
);

	qsm_pkg::cfg_t  cfg;
	qsm_pkg::cmd_t  cmd;
	qsm_pkg::stat_t st;
	logic           in_ready;

	assign item.ready = in_ready;

	qsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qsm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (item.valid),
		.in_req_type (item.req_type),
		.st          (st),
		.in_ready    (in_ready),
		.cmd         (cmd)
	);

	qsm_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.enc_a      (item.enc_a),
		.enc_b      (item.enc_b),
		.speed_unit (item.speed_unit),
		.st         (st),
		.result     (result)
	);

endmodule
